// File: rtl/core/crsf_pkg.sv
package crsf_pkg;

  localparam int BUFFER_DEPTH_DEF      = 64;
  localparam int MAX_FRAME_LEN_DEF     = 62;
  localparam int CHANNELS_DEF          = 16;
  localparam int RESCALED_CHANNELS_DEF = 4;
  localparam int STATS_BYTES_DEF       = 10;

  localparam int RESULT_CAP  = 64;
  localparam int CMDQ_DEPTH  = 4;

  localparam logic [7:0] CRC_POLY      = 8'hD5;
  localparam logic [7:0] TYPE_CHANNELS = 8'h16;
  localparam logic [7:0] TYPE_STATS    = 8'h14;

  localparam logic [2:0] KIND_FWD      = 3'd0;
  localparam logic [2:0] KIND_CHANNEL  = 3'd1;
  localparam logic [2:0] KIND_STATS    = 3'd2;
  localparam logic [2:0] KIND_LINK_UP  = 3'd3;
  localparam logic [2:0] KIND_LINK_DN  = 3'd4;

  localparam logic [3:0] CFG_PASSTHROUGH = 4'd0;
  localparam logic [3:0] CFG_PKT_TIMEOUT = 4'd1;
  localparam logic [3:0] CFG_FAILSAFE    = 4'd2;
  localparam logic [3:0] CFG_ADDRESS     = 4'd3;
  localparam logic [3:0] CFG_IN_MIN      = 4'd4;
  localparam logic [3:0] CFG_IN_MAX      = 4'd5;
  localparam logic [3:0] CFG_OUT_MIN     = 4'd6;
  localparam logic [3:0] CFG_OUT_MAX     = 4'd7;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         index;
    logic signed [15:0] value;
    logic               last;
  } out_item_t;

  // command passed from parser to output side
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  index;
    logic [15:0] value;
    logic        rescale;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic               passthrough_enable;
    logic [15:0]        packet_timeout_ms;
    logic [15:0]        failsafe_ms;
    logic [7:0]         accept_address;
    logic [10:0]        in_min;
    logic [10:0]        in_max;
    logic signed [15:0] out_min;
    logic signed [15:0] out_max;
  } cfg_t;

endpackage

// File: rtl/core/crsf_ram.sv
module crsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/crsf_cmd_fifo.sv
module crsf_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  crsf_pkg::cmd_t    push_data,
  input  logic              pop,
  output crsf_pkg::cmd_t    pop_data,
  output logic              empty,
  output logic              full
);

  localparam int PW = $clog2(crsf_pkg::CMDQ_DEPTH);

  crsf_pkg::cmd_t slot_r [crsf_pkg::CMDQ_DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (PW+1)'(crsf_pkg::CMDQ_DEPTH));
  assign pop_data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !full) begin
      wptr_nxt = wptr_r + 1'b1;
      cnt_nxt  = cnt_nxt + 1'b1;
    end
    if (pop && !empty) begin
      rptr_nxt = rptr_r + 1'b1;
      cnt_nxt  = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push && !full) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/crsf_front.sv
module crsf_front #(
  parameter int BUFFER_DEPTH      = crsf_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_FRAME_LEN     = crsf_pkg::MAX_FRAME_LEN_DEF,
  parameter int CHANNELS          = crsf_pkg::CHANNELS_DEF,
  parameter int RESCALED_CHANNELS = crsf_pkg::RESCALED_CHANNELS_DEF,
  parameter int STATS_BYTES       = crsf_pkg::STATS_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  crsf_pkg::in_item_t  in_item,
  output logic                in_full,
  input  crsf_pkg::cfg_t      cfg,
  output logic                q_push,
  output crsf_pkg::cmd_t      q_data,
  input  logic                q_full
);

  localparam int PW   = $clog2(BUFFER_DEPTH);
  localparam int FW   = $clog2(BUFFER_DEPTH + 1);
  localparam int NEED = (CHANNELS * 11 + 7) / 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LEN   = 4'd1;
  localparam logic [3:0] S_LENW  = 4'd2;
  localparam logic [3:0] S_CRC   = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_ADDR  = 4'd5;
  localparam logic [3:0] S_TYPE  = 4'd6;
  localparam logic [3:0] S_CH    = 4'd7;
  localparam logic [3:0] S_ST    = 4'd8;
  localparam logic [3:0] S_FLUSH = 4'd9;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [8:0] j);
    logic [9:0] s;
    s = 10'(h) + 10'(j);
    if (s >= 10'(BUFFER_DEPTH)) s = s - 10'(BUFFER_DEPTH);
    return s[PW-1:0];
  endfunction

  function automatic logic [7:0] crc_byte(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ crsf_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [3:0]      state_r, state_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [7:0]      len_r, len_nxt;
  logic [8:0]      j_r, j_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic            match_r, match_nxt;
  logic [17:0]     acc_r, acc_nxt;
  logic [4:0]      nb_r, nb_nxt;
  logic [4:0]      ch_r, ch_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  crsf_pkg::cmd_t  pend_r, pend_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [15:0]     msb_r, msb_nxt, msc_r, msc_nxt;
  logic            link_r, link_nxt;
  logic [PW-1:0]   raddr_r, raddr_nxt;

  logic            we;
  logic [PW-1:0]   waddr;
  logic [7:0]      rdata;
  logic            emit_req, emit_go, stall, do_drop;
  crsf_pkg::cmd_t  emit_cmd;
  logic [8:0]      drop_amt;
  logic [17:0]     acc_add;
  logic [5:0]      nb_add;

  crsf_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_item.rx_byte),
    .raddr (raddr_nxt),
    .rdata (rdata)
  );

  assign in_full = (state_r != S_IDLE);
  assign waddr   = phys(head_r, 9'(fill_r));
  assign we      = (state_r == S_IDLE) && in_push && !in_item.action
                   && !cfg.passthrough_enable;

  assign acc_add = acc_r | (18'(rdata) << nb_r);
  assign nb_add  = 6'(nb_r) + 6'd8;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    j_nxt      = j_r;
    crc_nxt    = crc_r;
    match_nxt  = match_r;
    acc_nxt    = acc_r;
    nb_nxt     = nb_r;
    ch_nxt     = ch_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    msb_nxt    = msb_r;
    msc_nxt    = msc_r;
    link_nxt   = link_r;
    raddr_nxt  = raddr_r;
    emit_req   = 1'b0;
    emit_cmd   = '0;
    do_drop    = 1'b0;
    drop_amt   = '0;
    q_push     = 1'b0;
    q_data     = pend_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_push) begin
          cnt_nxt = '0;
          if (!in_item.action) begin
            msb_nxt = '0;
            if (cfg.passthrough_enable) begin
              pend_nxt   = '{kind: crsf_pkg::KIND_FWD, index: '0,
                             value: 16'(in_item.rx_byte), rescale: 1'b0, last: 1'b0};
              pend_v_nxt = 1'b1;
              state_nxt  = S_FLUSH;
            end else begin
              fill_nxt  = fill_r + 1'b1;
              state_nxt = S_LEN;
            end
          end else begin
            if (msb_r != 16'hFFFF) msb_nxt = msb_r + 1'b1;
            if (msc_r != 16'hFFFF) msc_nxt = msc_r + 1'b1;
            if (fill_r != '0 && msb_nxt > cfg.packet_timeout_ms) fill_nxt = '0;
            if (link_r && msc_nxt > cfg.failsafe_ms) begin
              pend_nxt   = '{kind: crsf_pkg::KIND_LINK_DN, index: '0, value: '0,
                             rescale: 1'b0, last: 1'b0};
              pend_v_nxt = 1'b1;
              link_nxt   = 1'b0;
            end
            state_nxt = S_FLUSH;
          end
        end
      end
      S_LEN: begin
        if (fill_r > FW'(1)) begin
          raddr_nxt = phys(head_r, 9'd1);
          state_nxt = S_LENW;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_LENW: begin
        len_nxt = rdata;
        if (rdata < 8'd3 || 9'(rdata) > 9'(MAX_FRAME_LEN)) begin
          do_drop  = 1'b1;
          drop_amt = 9'd1;
        end else if (10'(fill_r) >= 10'(rdata) + 10'd2) begin
          crc_nxt   = '0;
          j_nxt     = 9'd2;
          raddr_nxt = phys(head_r, 9'd2);
          state_nxt = S_CRC;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_CRC: begin
        crc_nxt = crc_byte(crc_r ^ rdata);
        if (j_r == 9'(len_r)) begin
          raddr_nxt = phys(head_r, 9'(len_r) + 9'd1);
          state_nxt = S_CMP;
        end else begin
          j_nxt     = j_r + 1'b1;
          raddr_nxt = phys(head_r, j_r + 9'd1);
        end
      end
      S_CMP: begin
        if (rdata == crc_r) begin
          raddr_nxt = phys(head_r, 9'd0);
          state_nxt = S_ADDR;
        end else begin
          do_drop  = 1'b1;
          drop_amt = 9'd1;
        end
      end
      S_ADDR: begin
        match_nxt = (rdata == cfg.accept_address);
        raddr_nxt = phys(head_r, 9'd2);
        state_nxt = S_TYPE;
      end
      S_TYPE: begin
        do_drop  = 1'b1;
        drop_amt = 9'(len_r) + 9'd2;
        if (match_r && rdata == crsf_pkg::TYPE_CHANNELS
            && 9'(len_r) >= 9'(NEED + 2)) begin
          do_drop   = 1'b0;
          emit_req  = !link_r;
          emit_cmd  = '{kind: crsf_pkg::KIND_LINK_UP, index: '0, value: '0,
                        rescale: 1'b0, last: 1'b0};
          link_nxt  = 1'b1;
          msc_nxt   = '0;
          acc_nxt   = '0;
          nb_nxt    = '0;
          ch_nxt    = '0;
          j_nxt     = 9'd3;
          raddr_nxt = phys(head_r, 9'd3);
          state_nxt = S_CH;
        end else if (match_r && rdata == crsf_pkg::TYPE_STATS
                     && 9'(len_r) >= 9'(STATS_BYTES + 2)) begin
          do_drop   = 1'b0;
          j_nxt     = 9'd3;
          raddr_nxt = phys(head_r, 9'd3);
          state_nxt = S_ST;
        end
      end
      S_CH: begin
        acc_nxt = acc_add;
        nb_nxt  = nb_add[4:0];
        if (nb_add >= 6'd11 && ch_r < 5'(CHANNELS)) begin
          emit_req = 1'b1;
          emit_cmd = '{kind: crsf_pkg::KIND_CHANNEL, index: ch_r[3:0],
                       value: 16'(acc_add[10:0]),
                       rescale: (ch_r < 5'(RESCALED_CHANNELS)), last: 1'b0};
          acc_nxt  = acc_add >> 11;
          nb_nxt   = 5'(nb_add - 6'd11);
          ch_nxt   = ch_r + 1'b1;
        end
        if (j_r == 9'(NEED + 2)) begin
          do_drop  = 1'b1;
          drop_amt = 9'(len_r) + 9'd2;
        end else begin
          j_nxt     = j_r + 1'b1;
          raddr_nxt = phys(head_r, j_r + 9'd1);
        end
      end
      S_ST: begin
        emit_req = 1'b1;
        emit_cmd = '{kind: crsf_pkg::KIND_STATS, index: 4'(j_r - 9'd3),
                     value: 16'(rdata), rescale: 1'b0, last: 1'b0};
        if (j_r == 9'(STATS_BYTES + 2)) begin
          do_drop  = 1'b1;
          drop_amt = 9'(len_r) + 9'd2;
        end else begin
          j_nxt     = j_r + 1'b1;
          raddr_nxt = phys(head_r, j_r + 9'd1);
        end
      end
      S_FLUSH: begin
        if (fill_r == FW'(BUFFER_DEPTH)) fill_nxt = '0;
        if (pend_v_r) begin
          if (!q_full) begin
            q_push      = 1'b1;
            q_data.last = 1'b1;
            pend_v_nxt  = 1'b0;
            state_nxt   = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_drop) begin
      state_nxt = S_LEN;
      if (10'(drop_amt) >= 10'(fill_r)) begin
        fill_nxt = '0;
      end else begin
        fill_nxt = fill_r - FW'(drop_amt);
        head_nxt = phys(head_r, drop_amt);
      end
    end

    // results past the cap are dropped; the held one is released when the next arrives, or at the flush, flagged last
    emit_go = emit_req && (cnt_r < 7'(crsf_pkg::RESULT_CAP));
    stall   = emit_go && pend_v_r && q_full;
    if (emit_go && !stall) begin
      cnt_nxt    = cnt_r + 1'b1;
      pend_nxt   = emit_cmd;
      pend_v_nxt = 1'b1;
      q_push     = pend_v_r;
    end

    if (stall) begin
      state_nxt = state_r;
      head_nxt  = head_r;
      fill_nxt  = fill_r;
      j_nxt     = j_r;
      acc_nxt   = acc_r;
      nb_nxt    = nb_r;
      ch_nxt    = ch_r;
      msc_nxt   = msc_r;
      link_nxt  = link_r;
      raddr_nxt = raddr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      head_r   <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      msb_r    <= '0;
      msc_r    <= '0;
      link_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      msb_r    <= msb_nxt;
      msc_r    <= msc_nxt;
      link_r   <= link_nxt;
    end
    len_r   <= len_nxt;
    j_r     <= j_nxt;
    crc_r   <= crc_nxt;
    match_r <= match_nxt;
    acc_r   <= acc_nxt;
    nb_r    <= nb_nxt;
    ch_r    <= ch_nxt;
    pend_r  <= pend_nxt;
    raddr_r <= raddr_nxt;
  end

endmodule

// File: rtl/core/crsf_back.sv
module crsf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  crsf_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  crsf_pkg::cmd_t      q_data,
  output logic                q_pop,
  output crsf_pkg::out_item_t out_item,
  output logic                out_empty,
  input  logic                out_pop
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_PREP = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_ABS  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_FIN  = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  logic [2:0]                state_r, state_nxt;
  crsf_pkg::cmd_t            cmd_r, cmd_nxt;
  logic signed [11:0]        dx_r, dx_nxt, den_r, den_nxt;
  logic signed [16:0]        rng_r, rng_nxt;
  logic signed [28:0]        prod_r, prod_nxt;
  logic [27:0]               quo_r, quo_nxt;
  logic [10:0]               rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic                      neg_r, neg_nxt;
  logic [4:0]                it_r, it_nxt;
  logic signed [15:0]        res_r, res_nxt;
  crsf_pkg::out_item_t       out_r, out_nxt;
  logic                      out_v_r, out_v_nxt;
  logic                      slot_free;
  logic [11:0]               rem2;
  logic [28:0]               pmag, dmag;
  logic signed [29:0]        sq, vsum;

  assign slot_free = !out_v_r || out_pop;
  assign out_item  = out_r;
  assign out_empty = !out_v_r;

  assign rem2 = {rem_r, quo_r[27]};
  assign pmag = prod_r[28] ? 29'(-prod_r) : 29'(prod_r);
  assign dmag = den_r[11] ? 29'(-den_r) : 29'(den_r);
  assign sq   = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  assign vsum = sq + 30'(cfg.out_min);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    dx_nxt    = dx_r;
    den_nxt   = den_r;
    rng_nxt   = rng_r;
    prod_nxt  = prod_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    it_nxt    = it_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r && !out_pop;
    q_pop     = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_data.rescale) begin
            q_pop     = 1'b1;
            cmd_nxt   = q_data;
            state_nxt = B_PREP;
          end else if (slot_free) begin
            q_pop     = 1'b1;
            out_nxt   = '{kind: q_data.kind, index: q_data.index,
                          value: $signed(q_data.value), last: q_data.last};
            out_v_nxt = 1'b1;
          end
        end
      end
      B_PREP: begin
        dx_nxt  = $signed({1'b0, cmd_r.value[10:0]}) - $signed({1'b0, cfg.in_min});
        den_nxt = $signed({1'b0, cfg.in_max}) - $signed({1'b0, cfg.in_min});
        rng_nxt = $signed({cfg.out_max[15], cfg.out_max})
                  - $signed({cfg.out_min[15], cfg.out_min});
        if (cfg.in_max == cfg.in_min) begin
          res_nxt   = cfg.out_min;
          state_nxt = B_DONE;
        end else begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        prod_nxt  = dx_r * rng_r;
        state_nxt = B_ABS;
      end
      B_ABS: begin
        quo_nxt   = pmag[27:0];
        dvs_nxt   = dmag[10:0];
        neg_nxt   = prod_r[28] ^ den_r[11];
        rem_nxt   = '0;
        it_nxt    = '0;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem2 >= {1'b0, dvs_r}) begin
          rem_nxt = 11'(rem2 - {1'b0, dvs_r});
          quo_nxt = {quo_r[26:0], 1'b1};
        end else begin
          rem_nxt = rem2[10:0];
          quo_nxt = {quo_r[26:0], 1'b0};
        end
        it_nxt = it_r + 1'b1;
        if (it_r == 5'd27) state_nxt = B_FIN;
      end
      B_FIN: begin
        if (vsum > 30'sd32767) begin
          res_nxt = 16'sh7FFF;
        end else if (vsum < -30'sd32768) begin
          res_nxt = 16'sh8000;
        end else begin
          res_nxt = vsum[15:0];
        end
        state_nxt = B_DONE;
      end
      B_DONE: begin
        if (slot_free) begin
          out_nxt   = '{kind: cmd_r.kind, index: cmd_r.index, value: res_r,
                        last: cmd_r.last};
          out_v_nxt = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
    cmd_r  <= cmd_nxt;
    dx_r   <= dx_nxt;
    den_r  <= den_nxt;
    rng_r  <= rng_nxt;
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    it_r   <= it_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule

// File: rtl/core/crsf_frame_receiver_unit.sv
// Serial frame receiver. Each input item is one received byte or one millisecond
// tick; results come out through a queue-style port, the final one of an item
// flagged with last. A byte item keeps the input full for the buffer scan:
// dropping leading bytes, the CRC check of a complete candidate frame, and for a
// frame that passes it, decoding of the payload bytes. The scan is bound by the
// single read port of the frame buffer. A tick keeps the input full while it
// updates the timers and flushes a pending result. Rescaled channels go through
// a serial divider on the output side, while the parser carries on behind a
// four-entry command queue.
// Configuration is taken at any time (cfg_ready is always high) but must only
// be written while the block is idle.
module crsf_frame_receiver_unit #(
  parameter int BUFFER_DEPTH      = crsf_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_FRAME_LEN     = crsf_pkg::MAX_FRAME_LEN_DEF,
  parameter int CHANNELS          = crsf_pkg::CHANNELS_DEF,
  parameter int RESCALED_CHANNELS = crsf_pkg::RESCALED_CHANNELS_DEF,
  parameter int STATS_BYTES       = crsf_pkg::STATS_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  crsf_pkg::in_item_t  in_item,
  output logic                in_full,
  output crsf_pkg::out_item_t out_item,
  output logic                out_empty,
  input  logic                out_pop,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  crsf_pkg::cfg_t cfg_r, cfg_nxt;
  logic           q_push, q_pop, q_empty, q_full;
  crsf_pkg::cmd_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        crsf_pkg::CFG_PASSTHROUGH: cfg_nxt.passthrough_enable = cfg_data[0];
        crsf_pkg::CFG_PKT_TIMEOUT: cfg_nxt.packet_timeout_ms  = cfg_data;
        crsf_pkg::CFG_FAILSAFE:    cfg_nxt.failsafe_ms        = cfg_data;
        crsf_pkg::CFG_ADDRESS:     cfg_nxt.accept_address     = cfg_data[7:0];
        crsf_pkg::CFG_IN_MIN:      cfg_nxt.in_min             = cfg_data[10:0];
        crsf_pkg::CFG_IN_MAX:      cfg_nxt.in_max             = cfg_data[10:0];
        crsf_pkg::CFG_OUT_MIN:     cfg_nxt.out_min            = $signed(cfg_data);
        crsf_pkg::CFG_OUT_MAX:     cfg_nxt.out_max            = $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{passthrough_enable: 1'b0, packet_timeout_ms: 16'd100,
                 failsafe_ms: 16'd1000, accept_address: 8'd200,
                 in_min: 11'd172, in_max: 11'd1811,
                 out_min: 16'sd191, out_max: 16'sd1792};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crsf_front #(
    .BUFFER_DEPTH      (BUFFER_DEPTH),
    .MAX_FRAME_LEN     (MAX_FRAME_LEN),
    .CHANNELS          (CHANNELS),
    .RESCALED_CHANNELS (RESCALED_CHANNELS),
    .STATS_BYTES       (STATS_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .cfg     (cfg_r),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  crsf_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .full      (q_full)
  );

  crsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
